FILE: src/fhg_pkg.sv
// Shared constants, types and functions of the fire heat grid generator.
// No dependencies; imported by fire_heat_grid_generator_top.
`default_nettype none

package fhg_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int BOTTOM_BASE = (GRID_HEIGHT - 1) * GRID_WIDTH;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int HEAT_W      = 6;
    localparam int COLOR_W     = 8;
    localparam int REQ_W       = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

    localparam logic [31:0] SEED_RESET    = 32'h1234abcd;
    localparam logic [31:0] RAND_ZERO_FIX = 32'h9e3779b9;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic [1:0] RND_LEFT  = 2'd0;
    localparam logic [1:0] RND_COOL  = 2'd1;
    localparam logic [1:0] RND_RIGHT = 2'd2;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgb;

    // One xorshift step (13, 17, 5); a zero result is replaced.
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return (y == 32'd0) ? RAND_ZERO_FIX : y;
    endfunction

    // Reduce a value of 0..7 modulo 3.
    function automatic logic [1:0] fold3(input logic [2:0] s);
        logic [2:0] t;
        if (s >= 3'd6) begin
            t = s - 3'd6;
        end else if (s >= 3'd3) begin
            t = s - 3'd3;
        end else begin
            t = s;
        end
        return t[1:0];
    endfunction

    // 32-bit value modulo 3: 4 and 16 are both 1 mod 3, so sum the digits.
    function automatic logic [1:0] mod3_32(input logic [31:0] x);
        logic [4:0] acc;
        logic [2:0] s;
        acc = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s   = {1'b0, x[4*i +: 2]} + {1'b0, x[4*i+2 +: 2]};
            acc = acc + {3'b000, fold3(s)};
        end
        s = {1'b0, acc[1:0]} + {1'b0, acc[3:2]} + {2'b00, acc[4]};
        return fold3(s);
    endfunction

    function automatic t_rgb palette(input logic [HEAT_W-1:0] h);
        logic [HEAT_W-1:0] hc;
        t_rgb c;
        hc = (h > HEAT_MAX) ? HEAT_MAX : h;
        if (hc == '0) begin
            c.red   = 8'd7;
            c.green = 8'd7;
            c.blue  = 8'd7;
        end else if (hc < 6'd12) begin
            c.red   = 8'd20 + 8'(hc) * 8'd20;
            c.green = 8'(hc) << 1;
            c.blue  = 8'd0;
        end else if (hc < 6'd26) begin
            c.red   = 8'd255;
            c.green = 8'(hc - 6'd11) * 8'd18;
            c.blue  = 8'd0;
        end else begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'(hc - 6'd25) * 8'd22;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/fhg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fhg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/fire_heat_grid_generator_top.sv
// Fire heat grid generator: heat grid in one RAM, xorshift generator, read-back
// with palette. Depends on fhg_pkg and fhg_ram.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid / tready           tuser: kind; tdata: col, row
//   m_axis    out        tvalid / tready           tdata: heat, red, green, blue
//   cfg       in         wr_en                     wr_data: seed
//
// After reset a clearing pass writes every cell, one per cycle; during it no word is
// accepted.
// An advance word issues one RAM read per cell of rows GRID_HEIGHT-1 down to 1;
// each new heat is written into the row above in the cycle after its read.
// A read word's RAM data arrives in ST_READ and is registered for ST_OUT.
// One word is in work at a time; tready drops until the result is taken.
`default_nettype none

module fire_heat_grid_generator_top
    import fhg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output      logic                   o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // col[5:0], row[11:6]
    input  wire logic [0:0]             i_s_axis_tuser,  // kind[0]
    output      logic                   o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output      logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // heat, red, green, blue
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [31:0]            i_cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADV,
        ST_TAIL,
        ST_READ,
        ST_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic [COL_W-1:0]       r_x, n_x;
    logic [ROW_W-1:0]       r_y, n_y;
    logic [31:0]            r_rand, n_rand;
    logic                   r_p_valid, n_p_valid;
    logic [COL_W-1:0]       r_p_x, n_p_x;
    logic [ADDR_W-1:0]      r_p_up, n_p_up;
    logic                   r_rd_ok, n_rd_ok;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [REQ_W-1:0]  w_req_col;
    logic [REQ_W-1:0]  w_req_row;
    logic              w_req_kind;
    logic              w_req_ok;
    logic [ADDR_W-1:0] w_req_addr;
    logic [ADDR_W-1:0] w_adv_addr;
    logic [1:0]        w_rnd;
    logic [HEAT_W-1:0] w_heat;
    logic [HEAT_W-1:0] w_nv;
    logic [ADDR_W-1:0] w_tgt_addr;
    t_rgb              w_rgb;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [HEAT_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;

    assign w_req_col  = i_s_axis_tdata[5:0];
    assign w_req_row  = i_s_axis_tdata[11:6];
    assign w_req_kind = i_s_axis_tuser[0];
    assign w_req_ok   = (32'(w_req_col) < GRID_WIDTH) && (32'(w_req_row) < GRID_HEIGHT);
    assign w_req_addr = ADDR_W'(ADDR_W'(w_req_row) * ADDR_W'(GRID_WIDTH))
                      + ADDR_W'(w_req_col);
    assign w_adv_addr = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(r_x);

    // r_rand holds the draw of the cell whose heat arrives this cycle
    assign w_rnd  = mod3_32(r_rand);
    assign w_nv   = (w_rnd == RND_COOL && w_heat != '0) ? w_heat - 1'b1 : w_heat;
    assign w_rgb  = palette(w_heat);

    always_comb begin
        w_tgt_addr = r_p_up;
        if (w_rnd == RND_LEFT && r_p_x != '0) begin
            w_tgt_addr = r_p_up - 1'b1;
        end else if (w_rnd == RND_RIGHT && r_p_x != COL_W'(GRID_WIDTH - 1)) begin
            w_tgt_addr = r_p_up + 1'b1;
        end
    end

    // The bottom row is never a write target, so it keeps the value of the clear.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = (r_clr_addr >= ADDR_W'(BOTTOM_BASE)) ? HEAT_MAX : '0;
        end else begin
            w_we    = r_p_valid;
            w_waddr = w_tgt_addr;
            w_wdata = w_nv;
        end
        w_raddr = (r_state == ST_ADV) ? w_adv_addr : w_req_addr;
    end

    fhg_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_heat)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_x        = r_x;
        n_y        = r_y;
        n_rand     = r_rand;
        n_p_valid  = (r_state == ST_ADV);
        n_p_x      = r_x;
        n_p_up     = ADDR_W'(w_adv_addr - ADDR_W'(GRID_WIDTH));
        n_rd_ok    = r_rd_ok;
        n_out_data = r_out_data;

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (w_req_kind == KIND_ADVANCE) begin
                        n_state = ST_ADV;
                        n_x     = '0;
                        n_y     = ROW_W'(GRID_HEIGHT - 1);
                    end else begin
                        n_state = ST_READ;
                        n_rd_ok = w_req_ok;
                    end
                end
            end
            ST_ADV: begin
                n_rand = xorshift32(r_rand);
                if (r_x == COL_W'(GRID_WIDTH - 1)) begin
                    n_x = '0;
                    if (r_y == ROW_W'(1)) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_y = r_y - 1'b1;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            ST_TAIL: begin
                n_out_data = '0;
                n_state    = ST_OUT;
            end
            ST_READ: begin
                if (r_rd_ok) begin
                    n_out_data = {2'b00, w_rgb.blue, w_rgb.green, w_rgb.red, w_heat};
                end else begin
                    n_out_data = '0;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // seed write reloads the generator
        if (i_cfg_wr_en) begin
            n_rand = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_rand     <= SEED_RESET;
            r_p_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rand     <= n_rand;
            r_p_valid  <= n_p_valid;
        end
        r_x        <= n_x;
        r_y        <= n_y;
        r_p_x      <= n_p_x;
        r_p_up     <= n_p_up;
        r_rd_ok    <= n_rd_ok;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
